@@ src/pba_pkg.sv @@
// Shared types and codes for the page bitmap allocator.
// Depends on nothing; used by pba_engine, pba_bitmap_ram and page_bitmap_allocator.
`default_nettype none

package pba_pkg;

   // Bitmap word geometry: one memory word holds 64 page bits
   localparam int WORD_W = 64;
   localparam int BIT_W  = 6;

   // Request actions
   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_DISPOSE = 2'd1;
   localparam logic [1:0] ACT_RECOVER = 2'd2;
   localparam logic [1:0] ACT_CHECK   = 2'd3;

   // Response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_BUSY    = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [11:0] page_id;
      logic        page_pinned;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] granted_page;
      logic [12:0] allocated_total;
      logic [12:0] page_total;
   } rsp_type;

endpackage

`default_nettype wire

@@ src/page_bitmap_allocator.sv @@
// Page bitmap allocator, first fit over a 64-bit-wide used-page bitmap memory.
// Allocate: scans the bitmap words in order, one read per cycle through the single memory
// read port, and reads the word holding the page just past the total when the file grows.
// Dispose, recover and check: read, modify/write, respond; out of range: respond without a read.
// One request at a time; req_ready returns in the same cycle that the registered response is first shown.
// Reset sweeps ceil(MAX_PAGES/64) bitmap words, one per cycle, with req_ready held low.
`default_nettype none

module page_bitmap_allocator #(
   parameter int MAX_PAGES = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire pba_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      pba_pkg::rsp_type rsp_data
);

   localparam int NWORDS    = (MAX_PAGES + pba_pkg::WORD_W - 1) / pba_pkg::WORD_W;
   localparam int MEM_DEPTH = (NWORDS < 2) ? 2 : NWORDS;
   localparam int AW        = $clog2(MEM_DEPTH);

   logic                       mem_wr_en;
   logic [AW-1:0]              mem_wr_addr;
   logic [pba_pkg::WORD_W-1:0] mem_wr_data;
   logic                       mem_rd_en;
   logic [AW-1:0]              mem_rd_addr;
   logic [pba_pkg::WORD_W-1:0] mem_rd_data;

   pba_engine #(
      .MAX_PAGES (MAX_PAGES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   pba_bitmap_ram #(
      .DEPTH (MEM_DEPTH),
      .AW    (AW)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   a_grant_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != pba_pkg::ST_OK) |-> rsp_data.granted_page == '0)
      else $error("granted page nonzero on a failed response");

   a_full_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == pba_pkg::ST_FULL)
         |-> rsp_data.page_total == 13'(MAX_PAGES))
      else $error("pool full reported below the page limit");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response raised in the cycle after a request transfer");

endmodule

`default_nettype wire

@@ src/pba_bitmap_ram.sv @@
// Used-page bitmap storage: one write port, one read port, registered read data.
// Depends on pba_pkg for the word width; instantiated by page_bitmap_allocator.
`default_nettype none

module pba_bitmap_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [pba_pkg::WORD_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output      logic [pba_pkg::WORD_W-1:0] rd_data
);

   logic [pba_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic [pba_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/pba_engine.sv @@
// Allocator sequencer: bitmap clear sweep, first-fit word scan, read-modify-write
// of one bitmap word per request, page counters and the response register.
// Depends on pba_pkg; drives the ports of pba_bitmap_ram.
`default_nettype none

module pba_engine #(
   parameter  int MAX_PAGES = 4096,
   localparam int NWORDS    = (MAX_PAGES + pba_pkg::WORD_W - 1) / pba_pkg::WORD_W,
   localparam int MEM_DEPTH = (NWORDS < 2) ? 2 : NWORDS,
   localparam int AW        = $clog2(MEM_DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire pba_pkg::req_type           req_data,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      pba_pkg::rsp_type           rsp_data,
   output      logic                       mem_wr_en,
   output      logic [AW-1:0]              mem_wr_addr,
   output      logic [pba_pkg::WORD_W-1:0] mem_wr_data,
   output      logic                       mem_rd_en,
   output      logic [AW-1:0]              mem_rd_addr,
   input  wire logic [pba_pkg::WORD_W-1:0] mem_rd_data
);

   localparam int CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int PAGE_W = $clog2(MAX_PAGES);
   localparam int WW     = pba_pkg::WORD_W;
   localparam int BW     = pba_pkg::BIT_W;
   localparam logic [BW-1:0] TOP_BIT  = BW'(WW - 1);
   localparam logic [WW-1:0] ONE_WORD = WW'(1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_EVAL,
      S_FIN
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic [1:0]       action_ff, action_in;
   logic             pinned_ff, pinned_in;
   logic             grow_ff, grow_in;
   logic [PAGE_W-1:0] target_ff, target_in;
   logic [AW-1:0]    issue_addr_ff, issue_addr_in;
   logic [AW-1:0]    eval_addr_ff, eval_addr_in;
   logic [1:0]       status_ff, status_in;
   logic [PAGE_W-1:0] granted_ff, granted_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] spanned_ff, spanned_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pba_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             out_free;
   logic             req_in_range;
   logic [AW-1:0]    req_word;
   logic [CNT_W-1:0] span_m1;
   logic [AW-1:0]    last_word;
   logic [BW-1:0]    last_bit;
   logic [WW-1:0]    scan_mask;
   logic [WW-1:0]    avail;
   logic             hit;
   logic [BW-1:0]    hit_bit;
   logic [BW-1:0]    tgt_bit;
   logic             tgt_set;
   logic [WW-1:0]    tgt_mask;
   logic [CNT_W-1:0] used_inc, used_dec, span_inc;
   logic             spanned_full;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      req_in_range = 32'(req_data.page_id) < MAX_PAGES;
      req_word     = AW'(req_data.page_id >> BW);
      span_m1      = spanned_ff - 1'b1;
      last_word    = AW'(span_m1 >> BW);
      last_bit     = BW'(span_m1);
      // only bits below the page total take part in the first-fit search
      scan_mask    = (eval_addr_ff == last_word) ? ({WW{1'b1}} >> (TOP_BIT - last_bit))
                                                 : {WW{1'b1}};
      avail        = ~mem_rd_data & scan_mask;
      hit          = |avail;
      hit_bit      = '0;
      for (int k = WW - 1; k >= 0; k--) begin
         if (avail[k]) begin
            hit_bit = BW'(k);
         end
      end
      tgt_bit      = BW'(target_ff);
      tgt_set      = mem_rd_data[tgt_bit];
      tgt_mask     = ONE_WORD << tgt_bit;
      used_inc     = (used_ff < CNT_W'(MAX_PAGES)) ? used_ff + 1'b1 : used_ff;
      used_dec     = (used_ff != '0) ? used_ff - 1'b1 : used_ff;
      span_inc     = (spanned_ff < CNT_W'(MAX_PAGES)) ? spanned_ff + 1'b1 : spanned_ff;
      spanned_full = spanned_ff >= CNT_W'(MAX_PAGES);
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      action_in     = action_ff;
      pinned_in     = pinned_ff;
      grow_in       = grow_ff;
      target_in     = target_ff;
      issue_addr_in = issue_addr_ff;
      eval_addr_in  = eval_addr_ff;
      status_in     = status_ff;
      granted_in    = granted_ff;
      used_in       = used_ff;
      spanned_in    = spanned_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      mem_wr_en     = 1'b0;
      mem_wr_addr   = AW'(target_ff >> BW);
      mem_wr_data   = mem_rd_data;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = issue_addr_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // sweep the bitmap after reset; the header page stays marked used
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = (clr_addr_ff == '0) ? ONE_WORD : '0;
            if (clr_addr_ff == AW'(NWORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               action_in  = req_data.action;
               pinned_in  = req_data.page_pinned;
               target_in  = PAGE_W'(req_data.page_id);
               grow_in    = 1'b0;
               granted_in = '0;
               status_in  = pba_pkg::ST_OK;
               if (req_data.action == pba_pkg::ACT_ALLOC) begin
                  mem_rd_en     = 1'b1;
                  mem_rd_addr   = '0;
                  eval_addr_in  = '0;
                  issue_addr_in = AW'(1);
                  state_in      = S_SCAN;
               end else if (!req_in_range) begin
                  status_in = pba_pkg::ST_INVALID;
                  state_in  = S_FIN;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = req_word;
                  state_in    = S_EVAL;
               end
            end
         end
         S_SCAN: begin
            priority if (hit) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = eval_addr_ff;
               mem_wr_data = mem_rd_data | (ONE_WORD << hit_bit);
               used_in     = used_inc;
               granted_in  = PAGE_W'({eval_addr_ff, hit_bit});
               state_in    = S_FIN;
            end else if (eval_addr_ff == last_word) begin
               if (spanned_full) begin
                  status_in = pba_pkg::ST_FULL;
                  state_in  = S_FIN;
               end else begin
                  // no hole: grow by the page just past the total
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = AW'(spanned_ff >> BW);
                  target_in   = PAGE_W'(spanned_ff);
                  grow_in     = 1'b1;
                  state_in    = S_EVAL;
               end
            end else begin
               mem_rd_en     = 1'b1;
               mem_rd_addr   = issue_addr_ff;
               eval_addr_in  = issue_addr_ff;
               issue_addr_in = issue_addr_ff + 1'b1;
            end
         end
         S_EVAL: begin
            state_in = S_FIN;
            if (grow_ff) begin
               if (!tgt_set) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = mem_rd_data | tgt_mask;
                  used_in     = used_inc;
               end
               spanned_in = span_inc;
               granted_in = target_ff;
            end else begin
               unique case (action_ff)
                  pba_pkg::ACT_DISPOSE: begin
                     if (pinned_ff) begin
                        status_in = pba_pkg::ST_BUSY;
                     end else if (tgt_set) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = mem_rd_data & ~tgt_mask;
                        used_in     = used_dec;
                     end
                  end
                  pba_pkg::ACT_RECOVER: begin
                     if (!tgt_set) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = mem_rd_data | tgt_mask;
                        used_in     = used_inc;
                        spanned_in  = span_inc;
                     end
                  end
                  pba_pkg::ACT_CHECK: begin
                     if ((CNT_W'(target_ff) >= spanned_ff) || !tgt_set) begin
                        status_in = pba_pkg::ST_INVALID;
                     end
                  end
                  default: begin
                     status_in = status_ff;
                  end
               endcase
            end
         end
         S_FIN: begin
            // hold the result until the response register is free
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.status          = status_ff;
               rsp_data_in.granted_page    = 12'(granted_ff);
               rsp_data_in.allocated_total = 13'(used_ff);
               rsp_data_in.page_total      = 13'(spanned_ff);
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         used_ff      <= CNT_W'(1);
         spanned_ff   <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         used_ff      <= used_in;
         spanned_ff   <= spanned_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff     <= action_in;
      pinned_ff     <= pinned_in;
      grow_ff       <= grow_in;
      target_ff     <= target_in;
      issue_addr_ff <= issue_addr_in;
      eval_addr_ff  <= eval_addr_in;
      status_ff     <= status_in;
      granted_ff    <= granted_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
